// ----- rtl/rsc_pkg.sv -----
package rsc_pkg;

	localparam int STACK_DEPTH_DEF = 128;
	localparam int Q_W = 32;
	localparam int DIV_W = 48;

	localparam logic [3:0] CMD_PUSH  = 4'd0;
	localparam logic [3:0] CMD_ADD   = 4'd1;
	localparam logic [3:0] CMD_SUB   = 4'd2;
	localparam logic [3:0] CMD_MUL   = 4'd3;
	localparam logic [3:0] CMD_DIV   = 4'd4;
	localparam logic [3:0] CMD_MOD   = 4'd5;
	localparam logic [3:0] CMD_PEEK  = 4'd6;
	localparam logic [3:0] CMD_DUP   = 4'd7;
	localparam logic [3:0] CMD_SWAP  = 4'd8;
	localparam logic [3:0] CMD_CLEAR = 4'd9;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_FULL  = 3'd1;
	localparam logic [2:0] ST_EMPTY = 3'd2;
	localparam logic [2:0] ST_ZDIV  = 3'd3;
	localparam logic [2:0] ST_ZMOD  = 3'd4;
	localparam logic [2:0] ST_SWAP  = 3'd5;
	localparam logic [2:0] ST_DUP   = 3'd6;

	// per-cell source select
	localparam logic [1:0] SEL_HOLD = 2'd0;
	localparam logic [1:0] SEL_UP   = 2'd1;
	localparam logic [1:0] SEL_DOWN = 2'd2;

	// whole-stack moves
	localparam logic [2:0] OP_HOLD = 3'd0;
	localparam logic [2:0] OP_PUSH = 3'd1;
	localparam logic [2:0] OP_POP  = 3'd2;
	localparam logic [2:0] OP_REPL = 3'd3;
	localparam logic [2:0] OP_SWAP = 3'd4;

	typedef struct packed {
		logic [3:0]              cmd;
		logic signed [Q_W-1:0]   operand;
	} rsc_req_t;

	typedef struct packed {
		logic signed [Q_W-1:0]   top_value;
		logic [2:0]              status;
		logic [7:0]              depth;
	} rsc_rsp_t;

	typedef struct packed {
		logic [1:0]     sel;
	} rsc_cell_ctl_t;

	function automatic logic [Q_W-1:0] sat_q(input logic signed [48:0] v);
		if (v > 49'sd2147483647)
			return 32'h7fff_ffff;
		else if (v < -49'sd2147483648)
			return 32'h8000_0000;
		else
			return v[Q_W-1:0];
	endfunction

	function automatic logic [1:0] cell_sel(input logic [2:0] op, input logic first,
			input logic second);
		logic [1:0] s;
		s = SEL_HOLD;
		case (op)
			OP_PUSH: s = SEL_UP;
			OP_POP:  s = SEL_DOWN;
			OP_REPL: s = first ? SEL_UP : SEL_DOWN;
			OP_SWAP: s = first ? SEL_DOWN : (second ? SEL_UP : SEL_HOLD);
			default: s = SEL_HOLD;
		endcase
		return s;
	endfunction

endpackage

// ----- rtl/rsc_cell.sv -----
module rsc_cell (
	input  logic                  clk,
	input  rsc_pkg::rsc_cell_ctl_t ctl,
	input  logic [rsc_pkg::Q_W-1:0] up_val,
	input  logic [rsc_pkg::Q_W-1:0] dn_val,
	output logic [rsc_pkg::Q_W-1:0] val
);
	import rsc_pkg::*;

	logic [Q_W-1:0] val_q;

	always_ff @(posedge clk) begin
		case (ctl.sel)
			SEL_UP:   val_q <= up_val;
			SEL_DOWN: val_q <= dn_val;
			default:  val_q <= val_q;
		endcase
	end

	assign val = val_q;

endmodule

// ----- rtl/rsc_div.sv -----
module rsc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [rsc_pkg::DIV_W-1:0] dividend,
	input  logic [rsc_pkg::Q_W-1:0]   divisor,
	output logic                      done,
	output logic [rsc_pkg::DIV_W-1:0] quo,
	output logic [rsc_pkg::Q_W-1:0]   rem
);
	import rsc_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic [Q_W-1:0]   rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [Q_W-1:0]   dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [Q_W:0]     trial;
	logic             fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DIV_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? Q_W'(trial - {1'b0, dvs_q}) : trial[Q_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// ----- rtl/rpn_stack_calculator.sv -----
// Each request is taken in idle and executed in the run state; mul then adds the
// multiply state, and div and mod with a nonzero divisor wait in the divide state.
// Throughput: one request at a time; the 48-step shared divider sets the worst case.
// done pulses one cycle with the result, and the receiver cannot stall it.
// Reset (arst_n low, asynchronous) empties the stack; stack cells are not cleared.
module rpn_stack_calculator #(
	parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rsc_pkg::rsc_req_t request,
	output logic              done,
	output rsc_pkg::rsc_rsp_t result
);
	import rsc_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_MUL  = 2'd2;
	localparam logic [1:0] S_DIV  = 2'd3;

	logic [1:0]            state_q, nxt_state;
	logic [CW-1:0]         count_q, nxt_count;
	logic [3:0]            cmd_q;
	logic [Q_W-1:0]        operand_q;
	logic signed [63:0]    prod_q;
	rsc_rsp_t              rsp_q;
	logic                  done_q;

	logic [Q_W-1:0]        cell_val [STACK_DEPTH];
	logic [Q_W-1:0]        new_val;
	logic [2:0]            op;
	logic                  finish;
	logic [2:0]            st;
	logic [Q_W-1:0]        topv;

	logic signed [Q_W-1:0] a, b;
	logic                  emp_a, emp_b;
	logic [Q_W-1:0]        amag, bmag;
	logic [2:0]            bin_st;
	logic [CW-1:0]         bin_cnt, pop_cnt;
	logic signed [47:0]    mulq;
	logic signed [48:0]    qs;
	logic [Q_W-1:0]        rv;

	logic                  div_start, div_done;
	logic [DIV_W-1:0]      div_dvd, div_quo;
	logic [Q_W-1:0]        div_dvs, div_rem;

	assign emp_b   = count_q == '0;
	assign emp_a   = count_q < CW'(2);
	assign b       = emp_b ? '0 : cell_val[0];
	assign a       = emp_a ? '0 : cell_val[1];
	assign amag    = a[Q_W-1] ? (~a + 1'b1) : a;
	assign bmag    = b[Q_W-1] ? (~b + 1'b1) : b;
	assign bin_st  = emp_a ? ST_EMPTY : ST_OK;
	assign bin_cnt = emp_a ? CW'(1) : count_q - CW'(1);
	assign pop_cnt = emp_b ? '0 : count_q - CW'(1);
	assign mulq    = prod_q[63:16] + {47'b0, prod_q[63] & (|prod_q[15:0])};
	assign qs      = (a[Q_W-1] ^ b[Q_W-1]) ? -$signed({1'b0, div_quo})
	                                       : $signed({1'b0, div_quo});
	assign rv      = {div_rem[15:0], 16'b0};

	assign div_dvd = (cmd_q == CMD_DIV) ? {amag, 16'b0} : {32'b0, amag[31:16]};
	assign div_dvs = (cmd_q == CMD_DIV) ? bmag : {16'b0, bmag[31:16]};

	always_comb begin
		nxt_state = state_q;
		nxt_count = count_q;
		op        = OP_HOLD;
		new_val   = '0;
		finish    = 1'b0;
		st        = ST_OK;
		topv      = '0;
		div_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start)
					nxt_state = S_RUN;
			end
			S_RUN: begin
				finish    = 1'b1;
				nxt_state = S_IDLE;
				case (cmd_q)
					CMD_PUSH: begin
						if (count_q < CW'(STACK_DEPTH)) begin
							op        = OP_PUSH;
							new_val   = operand_q;
							nxt_count = count_q + CW'(1);
						end else
							st = ST_FULL;
					end
					CMD_ADD: begin
						op        = OP_REPL;
						new_val   = sat_q(49'(a) + 49'(b));
						st        = bin_st;
						nxt_count = bin_cnt;
					end
					CMD_SUB: begin
						op        = OP_REPL;
						new_val   = sat_q(49'(a) - 49'(b));
						st        = bin_st;
						nxt_count = bin_cnt;
					end
					CMD_MUL: begin
						finish    = 1'b0;
						nxt_state = S_MUL;
					end
					CMD_DIV, CMD_MOD: begin
						if ((cmd_q == CMD_DIV) ? (bmag == '0) : (bmag[31:16] == '0)) begin
							// drop the divisor only
							op        = OP_POP;
							nxt_count = pop_cnt;
							st        = emp_b ? ST_EMPTY
							          : ((cmd_q == CMD_DIV) ? ST_ZDIV : ST_ZMOD);
						end else begin
							finish    = 1'b0;
							div_start = 1'b1;
							nxt_state = S_DIV;
						end
					end
					CMD_PEEK: begin
						if (emp_b)
							st = ST_EMPTY;
						else
							topv = cell_val[0];
					end
					CMD_DUP: begin
						if (emp_b)
							st = ST_DUP;
						else if (count_q >= CW'(STACK_DEPTH))
							st = ST_FULL;
						else begin
							op        = OP_PUSH;
							new_val   = cell_val[0];
							nxt_count = count_q + CW'(1);
						end
					end
					CMD_SWAP: begin
						if (emp_a)
							st = ST_SWAP;
						else
							op = OP_SWAP;
					end
					CMD_CLEAR: nxt_count = '0;
					default: ;
				endcase
			end
			S_MUL: begin
				finish    = 1'b1;
				nxt_state = S_IDLE;
				op        = OP_REPL;
				new_val   = sat_q(49'(mulq));
				st        = bin_st;
				nxt_count = bin_cnt;
			end
			S_DIV: begin
				if (div_done) begin
					finish    = 1'b1;
					nxt_state = S_IDLE;
					op        = OP_REPL;
					st        = bin_st;
					nxt_count = bin_cnt;
					if (cmd_q == CMD_DIV)
						new_val = sat_q(qs);
					else
						new_val = a[Q_W-1] ? (~rv + 1'b1) : rv;
				end
			end
			default: nxt_state = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= nxt_state;
			done_q  <= finish;
			if (finish)
				count_q <= nxt_count;
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == S_IDLE) begin
			cmd_q     <= request.cmd;
			operand_q <= request.operand;
		end
		if (state_q == S_RUN)
			prod_q <= a * b;
		if (finish) begin
			rsp_q.top_value <= topv;
			rsp_q.status    <= st;
			rsp_q.depth     <= 8'(nxt_count);
		end
	end

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		rsc_cell_ctl_t    ctl;
		logic [Q_W-1:0]   up_v, dn_v;
		assign ctl.sel = cell_sel(finish ? op : OP_HOLD, i == 0, i == 1);
		assign up_v    = (i == 0) ? new_val : cell_val[(i == 0) ? 0 : i - 1];
		assign dn_v    = cell_val[(i == STACK_DEPTH - 1) ? i : i + 1];
		rsc_cell u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.up_val (up_v),
			.dn_val (dn_v),
			.val    (cell_val[i])
		);
	end

	rsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = rsp_q;

`ifndef ASSERT_OFF
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but block not busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without request in flight");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");
	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside divide state");
`endif

endmodule
